// ===== rtl/srq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srq_pkg: shared constants, types and elaboration functions
// Date format, sidereal epoch and day ratio, CORDIC angle table and the word
// that travels down the rotation pipeline.
// ----------------------------------------------------------------------------
package srq_pkg;

    localparam int DATE_FRACTION_BITS   = 41;
    localparam int OUTPUT_FRACTION_BITS = 30;
    localparam int CORDIC_STAGES        = 32;

    localparam int DATE_W   = 64;
    localparam int TURNS_W  = 32;
    localparam int SIN_W    = 31;
    localparam int COS_W    = 32;
    localparam int CORDIC_W = 64;
    localparam int PROD_W   = 96;
    localparam int HALF_W   = 32;
    localparam int ANGLE_BITS = 60;
    localparam int PHASE_STAGES = 7;

    localparam logic [63:0] EPOCH_WHOLE_DAYS = 64'd2450448;
    localparam logic [63:0] EPOCH_SEC_NUM    = 64'd623018356;
    localparam logic [63:0] EPOCH_SEC_DEN    = 64'd864000000;
    localparam logic [63:0] RATIO_FRAC_NUM   = 64'd23590947;
    localparam logic [63:0] RATIO_FRAC_DEN   = 64'd8616409053;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic signed [CORDIC_W-1:0] GAIN_Q60 = 64'sd700114967507363241;
    localparam logic signed [CORDIC_W-1:0] HALF_PI = $signed(PI_Q60 >> 1);
    localparam logic [HALF_W-1:0] PI_LO = PI_Q60[HALF_W-1:0];
    localparam logic [HALF_W-1:0] PI_HI = PI_Q60[2*HALF_W-1:HALF_W];

    // num * 2^bits / den, rounded to nearest, for num < den
    function automatic logic [63:0] frac_div(input logic [63:0] num,
                                             input logic [63:0] den,
                                             input int bits);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = num;
        for (int k = 0; k < bits; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        if ((r << 1) >= den) begin
            q = q + 64'd1;
        end
        return q;
    endfunction

    // atan(2^-i) in radians, ANGLE_BITS fraction bits, series terms truncated
    function automatic logic signed [CORDIC_W-1:0] atan_pow2(input int i);
        logic [63:0] acc;
        logic [63:0] term;
        int k;
        int e;
        acc = '0;
        if (i == 0) begin
            acc = PI_Q60 >> 2;
        end else begin
            k = 0;
            e = i;
            while (e <= ANGLE_BITS) begin
                term = (64'd1 << (ANGLE_BITS - e)) / 64'(2 * k + 1);
                if (k[0]) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
                k = k + 1;
                e = i * (2 * k + 1);
            end
        end
        return $signed(acc);
    endfunction

    localparam logic [63:0] EPOCH =
        (EPOCH_WHOLE_DAYS << DATE_FRACTION_BITS)
        + (64'd1 << (DATE_FRACTION_BITS - 1))
        + frac_div(EPOCH_SEC_NUM, EPOCH_SEC_DEN, DATE_FRACTION_BITS);

    localparam logic [63:0] RATIO_FRAC = frac_div(RATIO_FRAC_NUM, RATIO_FRAC_DEN, 64);
    localparam logic [HALF_W-1:0] RATIO_LO = RATIO_FRAC[HALF_W-1:0];
    localparam logic [HALF_W-1:0] RATIO_HI = RATIO_FRAC[2*HALF_W-1:HALF_W];

    localparam int ROUND_SHIFT = ANGLE_BITS - OUTPUT_FRACTION_BITS;
    localparam logic signed [CORDIC_W-1:0] ROUND_BIAS = 64'sd1 <<< (ROUND_SHIFT - 1);
    localparam logic signed [CORDIC_W-1:0] OUT_ONE = 64'sd1 <<< OUTPUT_FRACTION_BITS;
    localparam logic signed [CORDIC_W-1:0] OUT_MINUS_ONE = -OUT_ONE;
    localparam logic [SIN_W-1:0] OUT_ONE_SIN = OUT_ONE[SIN_W-1:0];
    localparam logic signed [COS_W-1:0] OUT_ONE_COS = OUT_ONE[COS_W-1:0];
    localparam logic signed [COS_W-1:0] OUT_MINUS_ONE_COS = OUT_MINUS_ONE[COS_W-1:0];

    typedef struct packed {
        logic [TURNS_W-1:0]         turns;
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
    } t_cordic_word;

    typedef struct packed {
        logic [TURNS_W-1:0]      turns;
        logic [SIN_W-1:0]        sine;
        logic signed [COS_W-1:0] cosine;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/srq_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srq_if: request channels of the rotation block
// Date channel in, rotation result channel out, valid/ready handshake.
// ----------------------------------------------------------------------------
interface srq_date_if;
    logic                         valid;
    logic                         ready;
    logic [srq_pkg::DATE_W-1:0]   julian_date;

    modport source (output valid, output julian_date, input ready);
    modport sink   (input valid, input julian_date, output ready);
endinterface

interface srq_result_if;
    logic                                valid;
    logic                                ready;
    logic [srq_pkg::TURNS_W-1:0]         rotation_turns;
    logic [srq_pkg::SIN_W-1:0]           sine_half_angle;
    logic signed [srq_pkg::COS_W-1:0]    cosine_half_angle;

    modport source (output valid, output rotation_turns, output sine_half_angle,
                    output cosine_half_angle, input ready);
    modport sink   (input valid, input rotation_turns, input sine_half_angle,
                    input cosine_half_angle, output ready);
endinterface
`default_nettype wire

// ===== rtl/sidereal_rotation_quaternion_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sidereal_rotation_quaternion_top: Earth rotation quaternion from a date
// Julian date in, rotation angle in turns and the half-angle sine and
// cosine (z and scalar quaternion elements) out.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                      handshake
//  i_date    in   julian_date                                  valid / ready
//  o_result  out  rotation_turns, sine/cosine_half_angle       valid / ready
//
//  One request per cycle while the skid entry is free. The path runs through seven
//  phase stages, one stage per CORDIC iteration, rounding, result register.
//  Synchronous active-low reset clears the valid bits only.
//  A stalled result goes to a one-entry skid; while it is full, i_date.ready
//  is low and every stage up to the rounding register holds.
// ----------------------------------------------------------------------------
module sidereal_rotation_quaternion_top (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    srq_date_if.sink       i_date,
    srq_result_if.source   o_result
);

    logic                  w_advance;
    logic                  w_phase_v;
    srq_pkg::t_cordic_word w_phase_word;
    logic                  w_cordic_v;
    srq_pkg::t_cordic_word w_cordic_word;

    assign i_date.ready = w_advance;

    srq_phase u_phase (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (w_advance),
        .i_valid       (i_date.valid),
        .i_julian_date (i_date.julian_date),
        .o_valid       (w_phase_v),
        .o_word        (w_phase_word)
    );

    srq_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_valid   (w_phase_v),
        .i_word    (w_phase_word),
        .o_valid   (w_cordic_v),
        .o_word    (w_cordic_word)
    );

    srq_output u_output (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_cordic_v),
        .i_word    (w_cordic_word),
        .o_advance (w_advance),
        .o_result  (o_result)
    );

    // input backpressure only follows a stalled result
    a_ready_after_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_date.ready |-> $past(o_result.valid && !o_result.ready))
        else $error("input held off without a stalled result");

    // a taken result always frees the skid
    a_ready_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.ready |=> i_date.ready)
        else $error("skid still full after a result was taken");

    a_output_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.sine_half_angle <= srq_pkg::OUT_ONE_SIN
            && o_result.cosine_half_angle <= srq_pkg::OUT_ONE_COS
            && o_result.cosine_half_angle >= srq_pkg::OUT_MINUS_ONE_COS))
        else $error("half-angle result outside unit range");

endmodule
`default_nettype wire

// ===== rtl/srq_phase.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srq_phase: date to rotation angle
// Epoch subtract, multiply by the sidereal day ratio in 32-bit partial
// products, pick the turn fraction, scale to a half angle, fold the quadrant.
// ----------------------------------------------------------------------------
module srq_phase (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_advance,
    input  wire logic                          i_valid,
    input  wire logic [srq_pkg::DATE_W-1:0]    i_julian_date,
    output logic                               o_valid,
    output srq_pkg::t_cordic_word              o_word
);

    localparam int HW = srq_pkg::HALF_W;

    logic [srq_pkg::PHASE_STAGES-1:0] r_v;

    logic [srq_pkg::DATE_W:0]    n_diff;
    logic [srq_pkg::DATE_W-1:0]  r1_dlo;
    logic                        r1_neg;

    logic [2*HW-1:0] n_p00, n_p01, n_p10, n_p11, n_p20;
    logic [HW-1:0]   r2_p00;
    logic [2*HW-1:0] r2_p01, r2_p10, r2_p11, r2_p20;
    logic [2*HW-1:0] r2_dtop;

    logic [2*HW:0]   n_m1;
    logic [2*HW-1:0] n_m2;
    logic [HW-1:0]   r3_p00;
    logic [2*HW:0]   r3_m1;
    logic [2*HW-1:0] r3_m2;

    logic [srq_pkg::PROD_W-1:0]  n_acc;
    logic [srq_pkg::TURNS_W-1:0] r4_turns;

    logic [2*HW-1:0] n_qlo, n_qhi, r5_qlo, r5_qhi;
    logic [srq_pkg::TURNS_W-1:0] r5_turns;

    logic [srq_pkg::CORDIC_W-1:0]        n_half;
    logic signed [srq_pkg::CORDIC_W-1:0] r6_half;
    logic [srq_pkg::TURNS_W-1:0]         r6_turns;

    srq_pkg::t_cordic_word n_word;
    srq_pkg::t_cordic_word r7_word;

    // signed 65-bit difference: the borrow is the sign
    assign n_diff = {1'b0, i_julian_date} - {1'b0, srq_pkg::EPOCH};

    // difference times ratio fraction as 32-bit partial products
    assign n_p00 = r1_dlo[HW-1:0]    * srq_pkg::RATIO_LO;
    assign n_p01 = r1_dlo[HW-1:0]    * srq_pkg::RATIO_HI;
    assign n_p10 = r1_dlo[2*HW-1:HW] * srq_pkg::RATIO_LO;
    assign n_p11 = r1_dlo[2*HW-1:HW] * srq_pkg::RATIO_HI;
    // a negative difference sign-extends: add minus the ratio fraction at bit 64
    assign n_p20 = r1_neg ? (64'd0 - srq_pkg::RATIO_FRAC) : '0;

    // the integer part of the ratio adds the difference itself at bit 64
    assign n_m1 = {1'b0, r2_p01} + {1'b0, r2_p10};
    assign n_m2 = r2_p11 + r2_p20 + r2_dtop;

    // product bits 127:32; nothing below bit 32 carries upward
    assign n_acc = {r3_m2, {HW{1'b0}}}
                 + {{(srq_pkg::PROD_W-2*HW-1){1'b0}}, r3_m1}
                 + {{(srq_pkg::PROD_W-HW){1'b0}}, r3_p00};

    assign n_qlo = r4_turns * srq_pkg::PI_LO;
    assign n_qhi = r4_turns * srq_pkg::PI_HI;

    // bits 95:32 of turns * pi
    assign n_half = r5_qhi + {{HW{1'b0}}, r5_qlo[2*HW-1:HW]};

    always_comb begin
        n_word.turns = r6_turns;
        if (r6_half >= srq_pkg::HALF_PI) begin
            n_word.x = '0;
            n_word.y = srq_pkg::GAIN_Q60;
            n_word.z = r6_half - srq_pkg::HALF_PI;
        end else begin
            n_word.x = srq_pkg::GAIN_Q60;
            n_word.y = '0;
            n_word.z = r6_half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_advance) begin
            r_v <= {r_v[srq_pkg::PHASE_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r1_dlo   <= n_diff[srq_pkg::DATE_W-1:0];
            r1_neg   <= n_diff[srq_pkg::DATE_W];
            r2_p00   <= n_p00[2*HW-1:HW];
            r2_p01   <= n_p01;
            r2_p10   <= n_p10;
            r2_p11   <= n_p11;
            r2_p20   <= n_p20;
            r2_dtop  <= r1_dlo;
            r3_p00   <= r2_p00;
            r3_m1    <= n_m1;
            r3_m2    <= n_m2;
            r4_turns <= n_acc[srq_pkg::DATE_FRACTION_BITS +: srq_pkg::TURNS_W];
            r5_qlo   <= n_qlo;
            r5_qhi   <= n_qhi;
            r5_turns <= r4_turns;
            r6_half  <= $signed(n_half);
            r6_turns <= r5_turns;
            r7_word  <= n_word;
        end
    end

    assign o_valid = r_v[srq_pkg::PHASE_STAGES-1];
    assign o_word  = r7_word;

endmodule
`default_nettype wire

// ===== rtl/srq_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srq_cordic: rotation-mode CORDIC
// One register stage per iteration; each stage turns the vector by the
// next arctangent step toward zero residual angle.
// ----------------------------------------------------------------------------
module srq_cordic (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_advance,
    input  wire logic                  i_valid,
    input  srq_pkg::t_cordic_word      i_word,
    output logic                       o_valid,
    output srq_pkg::t_cordic_word      o_word
);

    localparam int N = srq_pkg::CORDIC_STAGES;

    logic [N-1:0]          r_v;
    srq_pkg::t_cordic_word r_st [N];
    srq_pkg::t_cordic_word stg  [N+1];

    assign stg[0] = i_word;

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam logic signed [srq_pkg::CORDIC_W-1:0] ANGLE = srq_pkg::atan_pow2(i);
        srq_pkg::t_cordic_word n_st;

        always_comb begin
            n_st = stg[i];
            if (!stg[i].z[srq_pkg::CORDIC_W-1]) begin
                n_st.x = stg[i].x - (stg[i].y >>> i);
                n_st.y = stg[i].y + (stg[i].x >>> i);
                n_st.z = stg[i].z - ANGLE;
            end else begin
                n_st.x = stg[i].x + (stg[i].y >>> i);
                n_st.y = stg[i].y - (stg[i].x >>> i);
                n_st.z = stg[i].z + ANGLE;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_advance) begin
                r_st[i] <= n_st;
            end
        end

        assign stg[i+1] = r_st[i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_advance) begin
            r_v <= {r_v[N-2:0], i_valid};
        end
    end

    assign o_valid = r_v[N-1];
    assign o_word  = stg[N];

endmodule
`default_nettype wire

// ===== rtl/srq_output.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srq_output: rounding, clamping and result register with skid
// Round the CORDIC vector to the output format, then hand results out
// through an output register backed by one skid entry.
// ----------------------------------------------------------------------------
module srq_output (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  srq_pkg::t_cordic_word  i_word,
    output logic                   o_advance,
    srq_result_if.source           o_result
);

    logic signed [srq_pkg::CORDIC_W-1:0] n_sin;
    logic signed [srq_pkg::CORDIC_W-1:0] n_cos;
    srq_pkg::t_result n_rnd;
    srq_pkg::t_result r_rnd;
    srq_pkg::t_result r_out;
    srq_pkg::t_result r_sk;
    logic r_rnd_v;
    logic r_out_v;
    logic r_sk_v;
    logic out_free;

    always_comb begin
        n_sin = (i_word.y + srq_pkg::ROUND_BIAS) >>> srq_pkg::ROUND_SHIFT;
        n_cos = (i_word.x + srq_pkg::ROUND_BIAS) >>> srq_pkg::ROUND_SHIFT;
        if (n_sin > srq_pkg::OUT_ONE) begin
            n_sin = srq_pkg::OUT_ONE;
        end
        if (n_sin < 0) begin
            n_sin = '0;
        end
        if (n_cos > srq_pkg::OUT_ONE) begin
            n_cos = srq_pkg::OUT_ONE;
        end
        if (n_cos < srq_pkg::OUT_MINUS_ONE) begin
            n_cos = srq_pkg::OUT_MINUS_ONE;
        end
        n_rnd.turns  = i_word.turns;
        n_rnd.sine   = n_sin[srq_pkg::SIN_W-1:0];
        n_rnd.cosine = n_cos[srq_pkg::COS_W-1:0];
    end

    // the pipeline moves only while the skid entry is free
    assign o_advance = !r_sk_v;
    assign out_free  = o_result.ready || !r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd_v <= 1'b0;
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else begin
            if (o_advance) begin
                r_rnd_v <= i_valid;
            end
            if (out_free) begin
                if (r_sk_v) begin
                    r_out_v <= 1'b1;
                    r_sk_v  <= 1'b0;
                end else begin
                    r_out_v <= r_rnd_v;
                end
            end else if (r_rnd_v && !r_sk_v) begin
                r_sk_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_rnd <= n_rnd;
        end
        if (out_free) begin
            r_out <= r_sk_v ? r_sk : r_rnd;
        end else if (!r_sk_v) begin
            r_sk <= r_rnd;
        end
    end

    assign o_result.valid             = r_out_v;
    assign o_result.rotation_turns    = r_out.turns;
    assign o_result.sine_half_angle   = r_out.sine;
    assign o_result.cosine_half_angle = r_out.cosine;

endmodule
`default_nettype wire
